// File: design/bimp_pkg.sv
// Shared types, character codes and classifier functions for the index message parser.
package bimp_pkg;

   localparam int NAME_LENGTH_DEFAULT = 64;

   localparam logic [15:0] CH_NUL   = 16'h0000;
   localparam logic [15:0] CH_LF    = 16'h000A;
   localparam logic [15:0] CH_CR    = 16'h000D;
   localparam logic [15:0] CH_SPACE = 16'h0020;
   localparam logic [15:0] CH_DOT   = 16'h002E;

   localparam logic [9:0]  TOPIC_MIN = 10'd1;
   localparam logic [9:0]  TOPIC_MAX = 10'd999;
   localparam logic [9:0]  TOPIC_SAT = 10'd1000;

   typedef enum logic [1:0] {
      PHASE_START  = 2'd0,
      PHASE_SUBID  = 2'd1,
      PHASE_DIGITS = 2'd2,
      PHASE_NAME   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAME_CHAR = 2'd0,
      KIND_TOPIC     = 2'd1,
      KIND_ACCEPTED  = 2'd2,
      KIND_CORRUPT   = 2'd3
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] name_char;
      logic [9:0]  topic_number;
   } result_type;

   function automatic logic is_letter(input logic [15:0] c);
      logic r;
      r = 1'b0;
      if ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A)) r = 1'b1;
      if (c == 16'h00AA || c == 16'h00B5 || c == 16'h00BA) r = 1'b1;
      if (c >= 16'h00C0 && c <= 16'h00FF && c != 16'h00D7 && c != 16'h00F7) r = 1'b1;
      return r;
   endfunction

   function automatic logic is_digit(input logic [15:0] c);
      return (c >= 16'h0030 && c <= 16'h0039);
   endfunction

endpackage

// File: design/bimp_parser.sv
// Parser state registers and per-word next-state and result logic.
module bimp_parser #(
   parameter int NAME_LENGTH = bimp_pkg::NAME_LENGTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 mode,
   input  logic [15:0]          character,
   output bimp_pkg::result_type result
);

   localparam int CW = $clog2(NAME_LENGTH + 1);

   bimp_pkg::phase_type phase_ff, phase_in;
   logic [9:0]          acc_ff, acc_in;
   logic                store_ff, store_in;
   logic [15:0]         held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                seen_ff, seen_in;
   logic                error_ff, error_in;

   logic [13:0]         num_ext;
   logic [3:0]          digit;

   assign digit   = character[3:0];
   assign num_ext = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {10'd0, digit};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bimp_pkg::PHASE_START;
         store_ff      <= 1'b0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         seen_ff       <= 1'b0;
         error_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         store_ff      <= store_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         seen_ff       <= seen_in;
         error_ff      <= error_in;
      end
      acc_ff  <= acc_in;
      held_ff <= held_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      store_in      = store_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      error_in      = error_ff;
      result        = '0;
      if (accept) begin
         if (mode) begin
            result.valid = 1'b1;
            result.kind  = (!error_ff && seen_ff && phase_ff == bimp_pkg::PHASE_START) ?
                           bimp_pkg::KIND_ACCEPTED : bimp_pkg::KIND_CORRUPT;
            phase_in      = bimp_pkg::PHASE_START;
            acc_in        = '0;
            store_in      = 1'b0;
            held_in       = '0;
            held_valid_in = 1'b0;
            count_in      = '0;
            seen_in       = 1'b0;
            error_in      = 1'b0;
         end else if (error_ff) begin
            // drop words until end of message
         end else if (character == bimp_pkg::CH_NUL) begin
            error_in = 1'b1;
         end else begin
            case (phase_ff)
               bimp_pkg::PHASE_START: begin
                  if (bimp_pkg::is_letter(character)) begin
                     phase_in = bimp_pkg::PHASE_SUBID;
                  end else if (bimp_pkg::is_digit(character)) begin
                     acc_in   = {6'd0, digit};
                     phase_in = bimp_pkg::PHASE_DIGITS;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               bimp_pkg::PHASE_SUBID: begin
                  if (bimp_pkg::is_letter(character)) begin
                     phase_in = bimp_pkg::PHASE_SUBID;
                  end else if (character == bimp_pkg::CH_SPACE) begin
                     store_in      = 1'b0;
                     held_valid_in = 1'b0;
                     held_in       = '0;
                     count_in      = '0;
                     phase_in      = bimp_pkg::PHASE_NAME;
                  end else if (bimp_pkg::is_digit(character)) begin
                     acc_in   = {6'd0, digit};
                     phase_in = bimp_pkg::PHASE_DIGITS;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               bimp_pkg::PHASE_DIGITS: begin
                  if (bimp_pkg::is_digit(character)) begin
                     acc_in = (num_ext > {4'd0, bimp_pkg::TOPIC_MAX}) ?
                              bimp_pkg::TOPIC_SAT : num_ext[9:0];
                  end else if (acc_ff < bimp_pkg::TOPIC_MIN || acc_ff > bimp_pkg::TOPIC_MAX ||
                               (character != bimp_pkg::CH_SPACE &&
                                character != bimp_pkg::CH_DOT)) begin
                     error_in = 1'b1;
                  end else begin
                     store_in      = (character == bimp_pkg::CH_SPACE);
                     held_valid_in = 1'b0;
                     held_in       = '0;
                     count_in      = '0;
                     phase_in      = bimp_pkg::PHASE_NAME;
                  end
               end
               bimp_pkg::PHASE_NAME: begin
                  if (!held_valid_ff) begin
                     if (character == bimp_pkg::CH_LF || character == bimp_pkg::CH_CR) begin
                        error_in = 1'b1;
                     end else begin
                        held_in       = character;
                        held_valid_in = 1'b1;
                     end
                  end else if (character == bimp_pkg::CH_LF) begin
                     seen_in       = 1'b1;
                     phase_in      = bimp_pkg::PHASE_START;
                     held_valid_in = 1'b0;
                     held_in       = '0;
                     count_in      = '0;
                     store_in      = 1'b0;
                     if (store_ff) begin
                        result.valid        = 1'b1;
                        result.kind         = bimp_pkg::KIND_TOPIC;
                        result.topic_number = acc_ff;
                     end
                  end else begin
                     held_in = character;
                     if (store_ff && count_ff < CW'(NAME_LENGTH)) begin
                        count_in         = count_ff + 1'b1;
                        result.valid     = 1'b1;
                        result.kind      = bimp_pkg::KIND_NAME_CHAR;
                        result.name_char = held_ff;
                     end
                  end
               end
               default: begin
                  error_in = 1'b1;
               end
            endcase
         end
      end
   end

   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      accept && mode |=> phase_ff == bimp_pkg::PHASE_START && !error_ff && !seen_ff)
      else $error("end of message did not clear parser state");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !mode && error_ff |-> !result.valid)
      else $error("result produced after error");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NAME_LENGTH))
      else $error("name count beyond limit");

endmodule

// File: design/bimp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module bimp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  bimp_pkg::result_type push,
   input  logic                 rsp_stall,
   output logic                 full,
   output logic                 rsp_valid,
   output bimp_pkg::result_type rsp_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   bimp_pkg::result_type main_ff, main_in;
   bimp_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word held with empty output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push.valid)
      else $error("word pushed into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid word lost on drain");

endmodule

// File: design/broadcast_index_message_parser.sv
// Top level of the cell broadcast index message parser.
// A result word is registered in the output register, or in the skid register while rsp_stall holds it.
// Throughput: one input word per cycle while req_stall is low; the parser state update is a single registered pass.
// req_stall rises only when both result registers are occupied under rsp_stall.
// Reset is synchronous and active high; parser returns to element start, buffer empties.
module broadcast_index_message_parser #(
   parameter int NAME_LENGTH = bimp_pkg::NAME_LENGTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_name_char,
   output logic [9:0]  rsp_topic_number
);

   bimp_pkg::result_type result;
   bimp_pkg::result_type rsp_data;
   logic                 full;
   logic                 accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   bimp_parser #(
      .NAME_LENGTH(NAME_LENGTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_mode),
      .character(req_character),
      .result   (result)
   );

   bimp_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (result),
      .rsp_stall(rsp_stall),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_name_char    = rsp_data.name_char;
   assign rsp_topic_number = rsp_data.topic_number;

endmodule
